@@ rtl/ccka_pkg.sv @@
// Shared types and constants for the clipped color-key alpha blit.
package ccka_pkg;

  localparam int unsigned ColW     = 11;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned DestW    = 13;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned KeyW     = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned DiffW    = ChanW + 1;
  localparam int unsigned ProdW    = 2 * ChanW + 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_VALUE    = 3'd0,
    REG_TRANSPARENCY = 3'd1,
    REG_DEST_X       = 3'd2,
    REG_DEST_Y       = 3'd3,
    REG_CLIP_LEFT    = 3'd4,
    REG_CLIP_TOP     = 3'd5,
    REG_CLIP_RIGHT   = 3'd6,
    REG_CLIP_BOTTOM  = 3'd7
  } cfg_reg_e;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;

  typedef struct packed {
    logic signed [DestW-1:0] col;
    logic signed [DestW-1:0] row;
    logic                    key_miss;
    logic [PixW-1:0]         src_rgb;
    logic [PixW-1:0]         old_rgb;
    diff_t [2:0]             diff;
  } stg1_t;

  typedef struct packed {
    logic signed [DestW-1:0] col;
    logic signed [DestW-1:0] row;
    logic                    we;
    logic [PixW-1:0]         src_rgb;
    logic [PixW-1:0]         old_rgb;
    prod_t [2:0]             prod;
  } stg2_t;

endpackage

@@ rtl/clipped_color_key_alpha_blit.sv @@
// Clipped color-key blit with alpha blend: three-stage streaming pixel pipeline.
//
// One source pixel word enters per cycle and passes through the three
// register stages in order (offset add and channel differences, clip
// compare and the 9x8 blend multiplies, blend floor-shift and output
// select). Each stage holds its word while the next one is full and
// stalled, so throughput stays at one word per cycle while the output
// side keeps up. A word is written at (dest_x + src_col,
// dest_y + src_row) when that point lies inside the inclusive clip rectangle
// and its red byte differs from the key; dest_new otherwise carries dest_old.
// Configuration writes take effect at once and belong in idle periods.
module clipped_color_key_alpha_blit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ccka_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ccka_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_col, src_row, src_red, src_green, src_blue, dest_old, zero pad
  input  logic [ccka_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dest_col, dest_row, dest_new, zero pad
  output logic [ccka_pkg::OutDataW-1:0]     m_axis_tdata,
  // write_enable
  output logic                              m_axis_tuser
);
  import ccka_pkg::*;

  logic [KeyW-1:0]          key_q;
  logic [ChanW-1:0]         transp_q;
  logic signed [CoordW-1:0] dest_x_q, dest_y_q;
  logic signed [CoordW-1:0] clip_l_q, clip_t_q, clip_r_q, clip_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= KeyW'(256);
      transp_q <= '0;
      dest_x_q <= '0;
      dest_y_q <= '0;
      clip_l_q <= '0;
      clip_t_q <= '0;
      clip_r_q <= CoordW'(2047);
      clip_b_q <= CoordW'(2047);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_VALUE:    key_q    <= cfg_data_i[KeyW-1:0];
        REG_TRANSPARENCY: transp_q <= cfg_data_i[ChanW-1:0];
        REG_DEST_X:       dest_x_q <= cfg_data_i;
        REG_DEST_Y:       dest_y_q <= cfg_data_i;
        REG_CLIP_LEFT:    clip_l_q <= cfg_data_i;
        REG_CLIP_TOP:     clip_t_q <= cfg_data_i;
        REG_CLIP_RIGHT:   clip_r_q <= cfg_data_i;
        REG_CLIP_BOTTOM:  clip_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3          = !v3_q || m_axis_tready;
  assign adv2          = !v2_q || adv3;
  assign adv1          = !v1_q || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Stage 1: offset add, key compare, channel differences
  logic [ColW-1:0]  in_col, in_row;
  logic [ChanW-1:0] in_r;
  logic [PixW-1:0]  in_src, in_old;
  stg1_t            s1_d, s1_q;

  assign in_col = s_axis_tdata[10:0];
  assign in_row = s_axis_tdata[21:11];
  assign in_r   = s_axis_tdata[29:22];
  assign in_src = {s_axis_tdata[29:22], s_axis_tdata[37:30], s_axis_tdata[45:38]};
  assign in_old = s_axis_tdata[69:46];

  always_comb begin
    s1_d.col      = DestW'(dest_x_q) + $signed({2'b00, in_col});
    s1_d.row      = DestW'(dest_y_q) + $signed({2'b00, in_row});
    s1_d.key_miss = {1'b0, in_r} != key_q;
    s1_d.src_rgb  = in_src;
    s1_d.old_rgb  = in_old;
    for (int i = 0; i < 3; i++) begin
      s1_d.diff[i] = $signed({1'b0, in_src[i*ChanW +: ChanW]})
                   - $signed({1'b0, in_old[i*ChanW +: ChanW]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
  end

  // Stage 2: clip test, blend products
  stg2_t             s2_d, s2_q;
  logic signed [DiffW-1:0] wgt;
  logic              in_clip;

  assign wgt = $signed({1'b0, 8'd255 - transp_q});

  always_comb begin
    in_clip = (s1_q.col >= DestW'(clip_l_q)) && (s1_q.col <= DestW'(clip_r_q))
           && (s1_q.row >= DestW'(clip_t_q)) && (s1_q.row <= DestW'(clip_b_q));
    s2_d.col     = s1_q.col;
    s2_d.row     = s1_q.row;
    s2_d.we      = in_clip && s1_q.key_miss;
    s2_d.src_rgb = s1_q.src_rgb;
    s2_d.old_rgb = s1_q.old_rgb;
    for (int i = 0; i < 3; i++) begin
      s2_d.prod[i] = ProdW'(s1_q.diff[i]) * ProdW'(wgt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) s2_q <= s2_d;
  end

  // Stage 3: floor-shift, add back, select output pixel
  logic [PixW-1:0]        blend_rgb, new_rgb;
  logic signed [ProdW-1:0] shifted [3];
  logic [OutDataW-1:0]    out_d, out_q;
  logic                   we_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = s2_q.prod[i] >>> 8;
      blend_rgb[i*ChanW +: ChanW] = s2_q.old_rgb[i*ChanW +: ChanW] + shifted[i][ChanW-1:0];
    end
    if (!s2_q.we) begin
      new_rgb = s2_q.old_rgb;
    end else if (transp_q == '0) begin
      new_rgb = s2_q.src_rgb;
    end else begin
      new_rgb = blend_rgb;
    end
    out_d = {{(OutDataW-2*DestW-PixW){1'b0}}, new_rgb, s2_q.row, s2_q.col};
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_q <= out_d;
      we_q  <= s2_q.we;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = we_q;

endmodule
